// File: rtl/core/eass_pkg.sv
// Shared types, constants and arithmetic helpers for the even-asphere sag/slope pipeline.
// No dependencies; imported by every module under rtl/core.
package eass_pkg;

    localparam int NUM_COEF      = 8;
    localparam int NUM_TERMS_DEF = 8;
    localparam int COEF_IDX_W    = $clog2(NUM_COEF);
    localparam int CFG_ADDR_W    = 4;
    localparam int COEF_W        = 48;
    localparam int POS_W         = 32;
    localparam int ACC_W         = 64;
    localparam int R2_W          = 44;
    localparam int R2_SHIFT      = 20;
    localparam int R2_FRAC       = 40;
    localparam int POS_FRAC      = 30;
    localparam int PRODR_W       = 110;
    localparam int PRODP_W       = 97;
    localparam int WIDE_W        = 72;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_R2  = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_R4  = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_R6  = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_R8  = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_R10 = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_R12 = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_R14 = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEF_R16 = 4'd7;

    localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0] OUT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] OUT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } point_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] sag;
        logic signed [COEF_W-1:0] slope_x;
        logic signed [COEF_W-1:0] slope_y;
        logic                     saturated;
    } result_t;

    // Operand set that travels down the Horner chain
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [R2_W-1:0]         r2;
        logic signed [ACC_W-1:0] h;
        logic signed [ACC_W-1:0] g;
        logic                    clip;
    } horner_t;

    // Partial products of a signed 64-bit value times unsigned r^2
    typedef struct packed {
        logic signed [54:0] hh;
        logic signed [54:0] hl;
        logic [53:0]        lh;
        logic [53:0]        ll;
    } r2_pp_t;

    // Partial products of a signed 64-bit value times a signed coordinate
    typedef struct packed {
        logic signed [63:0] hi;
        logic signed [64:0] lo;
    } pos_pp_t;

    function automatic r2_pp_t r2_mul_pp(input logic signed [ACC_W-1:0] a,
                                         input logic [R2_W-1:0] r2);
        r2_pp_t pp;
        pp.hh = 55'($signed(a[63:32])) * 55'($signed({1'b0, r2[43:22]}));
        pp.hl = 55'($signed(a[63:32])) * 55'($signed({1'b0, r2[21:0]}));
        pp.lh = 54'(a[31:0]) * 54'(r2[43:22]);
        pp.ll = 54'(a[31:0]) * 54'(r2[21:0]);
        return pp;
    endfunction

    function automatic logic signed [PRODR_W-1:0] r2_mul_sum(input r2_pp_t pp);
        logic signed [PRODR_W-1:0] s;
        s = (PRODR_W'(pp.hh) <<< 54) + (PRODR_W'(pp.hl) <<< 32)
            + (PRODR_W'(pp.lh) << 22) + PRODR_W'(pp.ll);
        return s;
    endfunction

    function automatic pos_pp_t pos_mul_pp(input logic signed [ACC_W-1:0] a,
                                           input logic signed [POS_W-1:0] p);
        pos_pp_t pp;
        pp.hi = 64'($signed(a[63:32])) * 64'(p);
        pp.lo = 65'($signed({1'b0, a[31:0]})) * 65'(p);
        return pp;
    endfunction

    function automatic logic signed [PRODP_W-1:0] pos_mul_sum(input pos_pp_t pp);
        logic signed [PRODP_W-1:0] s;
        s = (PRODP_W'(pp.hi) <<< 32) + PRODP_W'(pp.lo);
        return s;
    endfunction

    function automatic logic ovf64(input logic signed [WIDE_W-1:0] v);
        return !((&v[WIDE_W-1:ACC_W-1]) || !(|v[WIDE_W-1:ACC_W-1]));
    endfunction

    function automatic logic signed [ACC_W-1:0] sat64(input logic signed [WIDE_W-1:0] v);
        if (ovf64(v))
        begin
            return v[WIDE_W-1] ? ACC_MIN : ACC_MAX;
        end
        return v[ACC_W-1:0];
    endfunction

    function automatic logic ovf48(input logic signed [WIDE_W-1:0] v);
        return !((&v[WIDE_W-1:COEF_W-1]) || !(|v[WIDE_W-1:COEF_W-1]));
    endfunction

    function automatic logic signed [COEF_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
        if (ovf48(v))
        begin
            return v[WIDE_W-1] ? OUT_MIN : OUT_MAX;
        end
        return v[COEF_W-1:0];
    endfunction

    function automatic logic add_ovf64(input logic signed [ACC_W-1:0] a,
                                       input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        return s[ACC_W] ^ s[ACC_W-1];
    endfunction

    function automatic logic signed [ACC_W-1:0] add_sat64(input logic signed [ACC_W-1:0] a,
                                                          input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] ^ s[ACC_W-1])
        begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

// File: rtl/core/eass_radius.sv
// Two-stage front end: squares the coordinates, forms r^2 in Q4.40, seeds the Horner pair.
// Depends on eass_pkg.
module eass_radius
    import eass_pkg::*;
#(
    parameter int LEAD_WEIGHT = 2 * NUM_TERMS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  point_t  in_data,
    input  coef_t   lead_coef,
    output logic    out_valid,
    input  logic    out_ready,
    output horner_t out_data
);

    localparam int NSTG = 2;
    localparam logic signed [ACC_W-1:0] WEIGHT_W = ACC_W'(LEAD_WEIGHT);

    logic [NSTG:0]   en;
    logic [NSTG-1:0] vld_reg, vld_next;

    point_t                  pt_s1_reg;
    logic signed [ACC_W-1:0] sqx_s1_reg, sqx_s1_next;
    logic signed [ACC_W-1:0] sqy_s1_reg, sqy_s1_next;
    horner_t                 out_reg, out_next;
    logic [ACC_W-1:0]        sq_sum;

    // Advance a stage when it is empty or the one below advances
    always_comb
    begin
        en[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        vld_next[1] = en[1] ? vld_reg[0] : vld_reg[1];
    end

    always_comb
    begin
        sqx_s1_next = ACC_W'(in_data.pos_x) * ACC_W'(in_data.pos_x);
        sqy_s1_next = ACC_W'(in_data.pos_y) * ACC_W'(in_data.pos_y);
        sq_sum      = ACC_W'(sqx_s1_reg) + ACC_W'(sqy_s1_reg);

        out_next.pos_x = pt_s1_reg.pos_x;
        out_next.pos_y = pt_s1_reg.pos_y;
        out_next.r2    = sq_sum[R2_W+R2_SHIFT-1:R2_SHIFT];
        out_next.h     = ACC_W'(lead_coef);
        out_next.g     = ACC_W'(lead_coef) * WEIGHT_W;
        out_next.clip  = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pt_s1_reg  <= in_data;
            sqx_s1_reg <= sqx_s1_next;
            sqy_s1_reg <= sqy_s1_next;
        end
        if (en[1])
        begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = out_reg;

endmodule

// File: rtl/core/eass_horner_step.sv
// One Horner step for sag and slope weight: four stages (partial products, sum, scale, add).
// Depends on eass_pkg.
module eass_horner_step
    import eass_pkg::*;
#(
    parameter int TERM_IDX = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  horner_t in_data,
    input  coef_t   coef,
    output logic    out_valid,
    input  logic    out_ready,
    output horner_t out_data
);

    localparam int NSTG = 4;
    localparam logic signed [ACC_W-1:0] WEIGHT_W = ACC_W'(2 * (TERM_IDX + 1));

    logic [NSTG:0]   en;
    logic [NSTG-1:0] vld_reg, vld_next;

    horner_t                   base_s1_reg, base_s2_reg, base_s3_reg, base_s3_next;
    r2_pp_t                    hpp_s1_reg, gpp_s1_reg;
    logic signed [PRODR_W-1:0] hprod_s2_reg, gprod_s2_reg;
    logic signed [WIDE_W-1:0]  hq, gq;
    logic signed [ACC_W-1:0]   coef_h, coef_g;
    horner_t                   out_reg, out_next;

    always_comb
    begin
        en[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    // Scale both products back to Q.40 (floor), clip to 64 bits
    always_comb
    begin
        hq = WIDE_W'($signed(hprod_s2_reg[PRODR_W-1:R2_FRAC]));
        gq = WIDE_W'($signed(gprod_s2_reg[PRODR_W-1:R2_FRAC]));
        base_s3_next      = base_s2_reg;
        base_s3_next.h    = sat64(hq);
        base_s3_next.g    = sat64(gq);
        base_s3_next.clip = base_s2_reg.clip | ovf64(hq) | ovf64(gq);
    end

    // Add the coefficient and its derivative weight
    always_comb
    begin
        coef_h        = ACC_W'(coef);
        coef_g        = ACC_W'(coef) * WEIGHT_W;
        out_next      = base_s3_reg;
        out_next.h    = add_sat64(base_s3_reg.h, coef_h);
        out_next.g    = add_sat64(base_s3_reg.g, coef_g);
        out_next.clip = base_s3_reg.clip | add_ovf64(base_s3_reg.h, coef_h)
                        | add_ovf64(base_s3_reg.g, coef_g);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            base_s1_reg <= in_data;
            hpp_s1_reg  <= r2_mul_pp(in_data.h, in_data.r2);
            gpp_s1_reg  <= r2_mul_pp(in_data.g, in_data.r2);
        end
        if (en[1])
        begin
            base_s2_reg  <= base_s1_reg;
            hprod_s2_reg <= r2_mul_sum(hpp_s1_reg);
            gprod_s2_reg <= r2_mul_sum(gpp_s1_reg);
        end
        if (en[2])
        begin
            base_s3_reg <= base_s3_next;
        end
        if (en[3])
        begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = out_reg;

endmodule

// File: rtl/core/eass_output.sv
// Final three stages: sag = h * r^2, slopes = g * x and g * y, saturation to Q8.40.
// Depends on eass_pkg.
module eass_output
    import eass_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  horner_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int NSTG = 3;

    logic [NSTG:0]   en;
    logic [NSTG-1:0] vld_reg, vld_next;

    r2_pp_t                    sag_pp_s1_reg;
    pos_pp_t                   sx_pp_s1_reg, sy_pp_s1_reg;
    logic                      clip_s1_reg, clip_s2_reg;
    logic signed [PRODR_W-1:0] sag_s2_reg;
    logic signed [PRODP_W-1:0] sx_s2_reg, sy_s2_reg;
    logic signed [WIDE_W-1:0]  sag_q, sx_q, sy_q;
    result_t                   out_reg, out_next;

    always_comb
    begin
        en[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_comb
    begin
        sag_q = WIDE_W'($signed(sag_s2_reg[PRODR_W-1:R2_FRAC]));
        sx_q  = WIDE_W'($signed(sx_s2_reg[PRODP_W-1:POS_FRAC]));
        sy_q  = WIDE_W'($signed(sy_s2_reg[PRODP_W-1:POS_FRAC]));
        out_next.sag       = sat48(sag_q);
        out_next.slope_x   = sat48(sx_q);
        out_next.slope_y   = sat48(sy_q);
        out_next.saturated = clip_s2_reg | ovf48(sag_q) | ovf48(sx_q) | ovf48(sy_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sag_pp_s1_reg <= r2_mul_pp(in_data.h, in_data.r2);
            sx_pp_s1_reg  <= pos_mul_pp(in_data.g, in_data.pos_x);
            sy_pp_s1_reg  <= pos_mul_pp(in_data.g, in_data.pos_y);
            clip_s1_reg   <= in_data.clip;
        end
        if (en[1])
        begin
            sag_s2_reg  <= r2_mul_sum(sag_pp_s1_reg);
            sx_s2_reg   <= pos_mul_sum(sx_pp_s1_reg);
            sy_s2_reg   <= pos_mul_sum(sy_pp_s1_reg);
            clip_s2_reg <= clip_s1_reg;
        end
        if (en[2])
        begin
            out_reg <= out_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = out_reg;

endmodule

// File: rtl/core/even_asphere_sag_slope.sv
// Even-asphere polynomial sag and x/y slope unit, Horner evaluation in r^2, Q8.40 results.
// Pipeline from point transaction to result:
// 2 front-end stages, 4 stages per Horner step (NUM_TERMS-1 steps), 3 output stages.
// Throughput: one point per cycle; each stage holds while the stage below is full and stalled.
// Reset: asynchronous, active low; clears all valid bits and zeroes the coefficient registers.
// Depends on eass_pkg, eass_radius, eass_horner_step, eass_output.
module even_asphere_sag_slope
    import eass_pkg::*;
#(
    parameter int NUM_TERMS = NUM_TERMS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Point channel
    input  logic                  pt_valid,
    output logic                  pt_ready,
    input  point_t                pt,
    // Result channel
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res,
    // Coefficient write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COEF_W-1:0]     cfg_wdata
);

    // Coefficient file: a_0 .. a_7; only the lowest NUM_TERMS take part
    coef_t coef_reg [NUM_COEF];

    // Handshake links along the chain: link 0 leaves the front end,
    // link s+1 leaves Horner step s, the last link feeds the output stages
    logic [NUM_TERMS-1:0] link_valid;
    logic [NUM_TERMS-1:0] link_ready;
    horner_t              link_data [NUM_TERMS];

    // Writes are always taken; indexes past the last coefficient are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready && cfg_addr <= CFG_COEF_R16)
        begin
            coef_reg[cfg_addr[COEF_IDX_W-1:0]] <= cfg_wdata;
        end
    end

    // Front end: r^2 and the Horner seed from the highest used coefficient
    eass_radius #(
        .LEAD_WEIGHT (2 * NUM_TERMS)
    ) u_radius (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pt_valid),
        .in_ready  (pt_ready),
        .in_data   (pt),
        .lead_coef (coef_reg[NUM_TERMS-1]),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // One step per remaining coefficient, from a_(NUM_TERMS-2) down to a_0
    for (genvar s = 0; s < NUM_TERMS - 1; s++)
    begin : g_step
        eass_horner_step #(
            .TERM_IDX (NUM_TERMS - 2 - s)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[s]),
            .in_ready  (link_ready[s]),
            .in_data   (link_data[s]),
            .coef      (coef_reg[NUM_TERMS-2-s]),
            .out_valid (link_valid[s+1]),
            .out_ready (link_ready[s+1]),
            .out_data  (link_data[s+1])
        );
    end

    // Last multiply by r^2 for the sag, by x and y for the slopes; holds the output register
    eass_output u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[NUM_TERMS-1]),
        .in_ready  (link_ready[NUM_TERMS-1]),
        .in_data   (link_data[NUM_TERMS-1]),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_data  (res)
    );

    // A ready consumer lets every stage advance, so the input side is open too
    a_open_when_drained : assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> pt_ready)
        else $error("point channel blocked while result side is ready");

    // The input side closes only when the result register is full and stalled
    a_stall_from_output : assert property (@(posedge clk) disable iff (!rst_n)
        !pt_ready |-> (res_valid && !res_ready))
        else $error("point channel blocked without a stalled result");

    // No result can emerge right after reset: reset clears every valid bit
    a_empty_after_reset : assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid straight out of reset");

endmodule
